// ===== hdl/dtp_pkg.sv =====
// Shared types, constants and month-name tables for the date text parser.
package dtp_pkg;

    localparam int VALUE_BITS = 16;
    localparam int NAME_CHARS = 9;
    localparam int NAME_COUNT = 23;
    localparam int POS_BITS   = 4;
    localparam int ACC_COUNT  = 6;
    localparam int DATA_BITS  = 56;

    // Accumulator slots
    localparam int ACC_PREFIX     = 0;
    localparam int ACC_DAY_SPACE  = 1;
    localparam int ACC_DAY_SLASH  = 2;
    localparam int ACC_YEAR_COMMA = 3;
    localparam int ACC_YEAR_SLASH = 4;
    localparam int ACC_YEAR_SPACE = 5;

    // Format codes
    localparam logic [1:0] FMT_NONE  = 2'd0;
    localparam logic [1:0] FMT_COMMA = 2'd1;
    localparam logic [1:0] FMT_SLASH = 2'd2;
    localparam logic [1:0] FMT_SPACE = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FORMAT = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NO_DIGITS = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Separator characters
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FRESH,
        PH_BLANK,
        PH_DIGITS,
        PH_DONE,
        PH_OVER,
        PH_BAD
    } phase_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] num;
        phase_t                phase;
    } acc_t;

    typedef struct packed {
        logic                          seen_comma;
        logic                          seen_slash;
        logic [1:0]                    space_count;
        logic                          at_start;
        logic [NAME_COUNT-1:0]         name_mask;
        logic [POS_BITS-1:0]           name_pos;
        acc_t [ACC_COUNT-1:0]          acc;
    } scan_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] year_value;
        logic [VALUE_BITS-1:0] month_value;
        logic [VALUE_BITS-1:0] day_value;
        logic [1:0]            format_code;
        logic [2:0]            parse_status;
    } result_t;

    // Month names, last character in the lowest byte
    localparam logic [NAME_CHARS*8-1:0] NAME_TEXT [NAME_COUNT] = '{
        "January", "Jan", "February", "Feb", "March", "Mar", "April", "Apr",
        "May", "June", "Jun", "July", "Jul", "August", "Aug", "September",
        "Sep", "October", "Oct", "November", "Nov", "December", "Dec"
    };

    localparam logic [POS_BITS-1:0] NAME_LEN [NAME_COUNT] = '{
        4'd7, 4'd3, 4'd8, 4'd3, 4'd5, 4'd3, 4'd5, 4'd3,
        4'd3, 4'd4, 4'd3, 4'd4, 4'd3, 4'd6, 4'd3, 4'd9,
        4'd3, 4'd7, 4'd3, 4'd8, 4'd3, 4'd8, 4'd3
    };

    localparam logic [3:0] NAME_MONTH [NAME_COUNT] = '{
        4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9,
        4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12
    };

    // Character of a month name at a position; valid only below its length
    function automatic logic [7:0] name_char(input int idx, input logic [POS_BITS-1:0] pos);
        logic [POS_BITS-1:0]     back;
        logic [NAME_CHARS*8-1:0] shifted;
        back    = NAME_LEN[idx] - pos - 1'b1;
        shifted = NAME_TEXT[idx] >> {back, 3'b000};
        return shifted[7:0];
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
    endfunction

    // Status that an accumulator reports when read
    function automatic logic [2:0] acc_status(input acc_t a);
        logic [2:0] st;
        case (a.phase)
            PH_DIGITS, PH_DONE: st = ST_OK;
            PH_OVER:            st = ST_OVERFLOW;
            PH_IDLE, PH_FRESH:  st = ST_EMPTY;
            default:            st = ST_NO_DIGITS;
        endcase
        return st;
    endfunction

    function automatic scan_t scan_reset();
        scan_t s;
        s           = '0;
        s.at_start  = 1'b1;
        s.name_mask = '1;
        return s;
    endfunction

endpackage

// ===== hdl/dtp_acc.sv =====
// One decimal number accumulator: restart, blank skip, digit fold and overflow.
module dtp_acc (
    input  dtp_pkg::acc_t acc_in,
    input  logic          start,
    input  logic [7:0]    char_code,
    output dtp_pkg::acc_t acc_out
);
    import dtp_pkg::*;

    acc_t                  base;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [VALUE_BITS+3:0] folded;

    // Apply restart, then feed the character
    always_comb begin
        base = acc_in;
        if (start) begin
            base.num   = '0;
            base.phase = PH_FRESH;
        end
        is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
        digit    = 4'(char_code - CH_ZERO);
        // num * 10 + digit as shift-and-add
        folded   = {1'b0, base.num, 3'b000} + {3'b000, base.num, 1'b0}
                 + {{VALUE_BITS{1'b0}}, digit};
        acc_out  = base;
        case (base.phase)
            PH_FRESH, PH_BLANK: begin
                if (is_blank(char_code)) begin
                    acc_out.phase = PH_BLANK;
                end else if (is_digit) begin
                    acc_out.num   = {{(VALUE_BITS-4){1'b0}}, digit};
                    acc_out.phase = PH_DIGITS;
                end else begin
                    acc_out.phase = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    if (folded[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
                        acc_out.phase = PH_OVER;
                    end else begin
                        acc_out.num = folded[VALUE_BITS-1:0];
                    end
                end else begin
                    acc_out.phase = PH_DONE;
                end
            end
            default: begin
                acc_out = base;
            end
        endcase
    end

endmodule

// ===== hdl/dtp_scan.sv =====
// Per-character scan state and the end-of-string snapshot register.
module dtp_scan (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_accept,
    input  logic           in_last,
    input  logic [7:0]     char_code,
    input  logic           snap_adv,
    output logic           snap_valid,
    output dtp_pkg::scan_t snap
);
    import dtp_pkg::*;

    scan_t                state_reg;
    scan_t                state_next;
    scan_t                snap_reg;
    logic                 snap_valid_reg;
    logic                 is_space;
    logic [ACC_COUNT-1:0] start;
    acc_t [ACC_COUNT-1:0] fed;

    assign is_space = (char_code == CH_SPACE);

    // Restart strobes that act before the character is fed
    always_comb begin
        start                 = '0;
        start[ACC_PREFIX]     = state_reg.at_start;
        start[ACC_DAY_SPACE]  = is_space && (state_reg.space_count == 2'd0);
        start[ACC_YEAR_SPACE] = is_space;
    end

    // Feed all six accumulators in parallel
    for (genvar g = 0; g < ACC_COUNT; g++) begin : g_acc
        dtp_acc u_acc (
            .acc_in    (state_reg.acc[g]),
            .start     (start[g]),
            .char_code (char_code),
            .acc_out   (fed[g])
        );
    end

    // Separator tracking, name match and post-feed restarts
    always_comb begin
        state_next     = state_reg;
        state_next.acc = fed;
        if ((state_reg.space_count == 2'd0) && !is_space) begin
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (!((state_reg.name_pos < NAME_LEN[i]) &&
                      (name_char(i, state_reg.name_pos) == char_code))) begin
                    state_next.name_mask[i] = 1'b0;
                end
            end
            if (state_reg.name_pos != '1) begin
                state_next.name_pos = state_reg.name_pos + 1'b1;
            end
        end
        if ((char_code == CH_COMMA) && !state_reg.seen_comma) begin
            state_next.acc[ACC_YEAR_COMMA].num   = '0;
            state_next.acc[ACC_YEAR_COMMA].phase = PH_FRESH;
            state_next.seen_comma                = 1'b1;
        end
        if (char_code == CH_SLASH) begin
            if (!state_reg.seen_slash) begin
                state_next.acc[ACC_DAY_SLASH].num   = '0;
                state_next.acc[ACC_DAY_SLASH].phase = PH_FRESH;
            end
            state_next.acc[ACC_YEAR_SLASH].num   = '0;
            state_next.acc[ACC_YEAR_SLASH].phase = PH_FRESH;
            state_next.seen_slash                = 1'b1;
        end
        if (is_space && !state_reg.space_count[1]) begin
            state_next.space_count = state_reg.space_count + 2'd1;
        end
        state_next.at_start = 1'b0;
    end

    // Advance scan state; clear it after the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scan_reset();
        end else if (in_accept) begin
            state_reg <= in_last ? scan_reset() : state_next;
        end
    end

    // Snapshot valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_adv) begin
            snap_valid_reg <= in_accept && in_last;
        end
    end

    // Snapshot payload: hold the state as it stands after the final character
    always_ff @(posedge aclk) begin
        if (snap_adv && in_accept && in_last) begin
            snap_reg <= state_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== hdl/dtp_result.sv =====
// Format selection, error ranking and the result register.
module dtp_result (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             snap_valid,
    input  dtp_pkg::scan_t   snap,
    input  logic             out_ready,
    output logic             out_adv,
    output logic             out_valid,
    output dtp_pkg::result_t result
);
    import dtp_pkg::*;

    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    lead_space;
    logic    empty;
    logic    named;
    acc_t    year_acc;
    acc_t    day_acc;

    // Pick the fields of the chosen format and rank the errors
    always_comb begin
        res_next   = '0;
        year_acc   = '0;
        day_acc    = '0;
        empty      = 1'b0;
        named      = 1'b0;
        lead_space = (snap.name_pos == '0) && (snap.space_count != 2'd0);
        if (snap.seen_comma) begin
            res_next.format_code = FMT_COMMA;
            year_acc             = snap.acc[ACC_YEAR_COMMA];
            day_acc              = snap.acc[ACC_DAY_SPACE];
            empty                = lead_space;
        end else if (snap.seen_slash) begin
            res_next.format_code = FMT_SLASH;
            year_acc             = snap.acc[ACC_YEAR_SLASH];
            day_acc              = snap.acc[ACC_DAY_SLASH];
        end else if (snap.space_count[1]) begin
            res_next.format_code = FMT_SPACE;
            year_acc             = snap.acc[ACC_YEAR_SPACE];
            day_acc              = snap.acc[ACC_DAY_SPACE];
            empty                = lead_space;
        end
        if (res_next.format_code == FMT_NONE) begin
            res_next.parse_status = ST_NO_FORMAT;
        end else begin
            if ((year_acc.phase == PH_IDLE) || (year_acc.phase == PH_FRESH) ||
                (day_acc.phase == PH_IDLE) || (day_acc.phase == PH_FRESH)) begin
                empty = 1'b1;
            end
            if (empty) begin
                res_next.parse_status = ST_EMPTY;
            end else begin
                res_next.parse_status = acc_status(year_acc);
                res_next.year_value   = year_acc.num;
                // Exact month name match, not for the slash form
                if (res_next.format_code != FMT_SLASH) begin
                    for (int i = 0; i < NAME_COUNT; i++) begin
                        if (snap.name_mask[i] && (NAME_LEN[i] == snap.name_pos)) begin
                            res_next.month_value = {{(VALUE_BITS-4){1'b0}}, NAME_MONTH[i]};
                            named                = 1'b1;
                        end
                    end
                end
                if (!named) begin
                    res_next.month_value = snap.acc[ACC_PREFIX].num;
                    if (res_next.parse_status == ST_OK) begin
                        res_next.parse_status = acc_status(snap.acc[ACC_PREFIX]);
                    end
                end
                res_next.day_value = day_acc.num;
                if (res_next.parse_status == ST_OK) begin
                    res_next.parse_status = acc_status(day_acc);
                end
            end
        end
        // Drop values on any error
        if (res_next.parse_status != ST_OK) begin
            res_next.year_value  = '0;
            res_next.month_value = '0;
            res_next.day_value   = '0;
        end
    end

    assign out_adv = !out_valid_reg || out_ready;

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= snap_valid;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (out_adv && snap_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ===== hdl/date_text_parser.sv =====
// Top level of the streaming date text parser.
// Throughput: one character per cycle while m_tready does not stall the output, with no gaps between strings.
// The result passes through the snapshot register, then the result register,
// after the transfer of the final character.
// Reset: synchronous active-low aresetn clears the scan state and both valid
// flags; the parser is ready in the first cycle after reset.
module date_text_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,   // last_char
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] year_value, [31:16] month_value, [47:32] day_value,
    // [49:48] format_code, [52:50] parse_status, [55:53] zero
    output logic [dtp_pkg::DATA_BITS-1:0]   m_tdata
);
    import dtp_pkg::*;

    logic    in_accept;
    logic    snap_valid;
    logic    snap_adv;
    logic    out_adv;
    scan_t   snap;
    result_t result;

    // Snapshot stage moves when empty or when the result stage takes it
    assign snap_adv  = !snap_valid || out_adv;
    assign s_tready  = snap_adv;
    assign in_accept = s_tvalid && s_tready;

    dtp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_last    (s_tlast),
        .char_code  (s_tdata),
        .snap_adv   (snap_adv),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    dtp_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .out_ready  (m_tready),
        .out_adv    (out_adv),
        .out_valid  (m_tvalid),
        .result     (result)
    );

    // Pack the result transfer
    assign m_tdata = {3'b000, result.parse_status, result.format_code,
                      result.day_value, result.month_value, result.year_value};

endmodule

// ===== hdl/dtp_checker.sv =====
// Port-level checks on the date text parser and their binding.
module dtp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dtp_pkg::DATA_BITS-1:0] m_tdata
);
    import dtp_pkg::*;

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result and an open input straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input closed after reset");

    // Error results carry zero values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[52:50] != ST_OK) |-> (m_tdata[47:0] == 48'd0))
        else $error("nonzero value with error status");

    // No format goes with exactly the no-format status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[49:48] == FMT_NONE) == (m_tdata[52:50] == ST_NO_FORMAT)))
        else $error("format code and status disagree");

    // Status stays in its defined range and the padding stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[52:50] <= ST_OVERFLOW) && (m_tdata[55:53] == 3'b000))
        else $error("undefined status or padding set");

endmodule

bind date_text_parser dtp_checker u_dtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming date text parser: directed table, then random dates.
`timescale 1ns / 1ps

module testbench;
    import dtp_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int PHASE_ITEMS     = 290;
    localparam int PHASE_COUNT     = 4;
    localparam int GAP_PCT [PHASE_COUNT]   = '{0, 85, 0, 17};
    localparam int STALL_PCT [PHASE_COUNT] = '{0, 0, 85, 17};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;

    int send_gap_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_go        = 1'b0;
    bit hold_served    = 1'b0;
    int error_count    = 0;
    int result_count   = 0;

    result_t    dates_due [$];
    logic [7:0] line_q [$];

    // Month names and their numbers, in match order
    string month_txt [NAME_COUNT] = '{
        "January", "Jan", "February", "Feb", "March", "Mar", "April", "Apr",
        "May", "June", "Jun", "July", "Jul", "August", "Aug", "September",
        "Sep", "October", "Oct", "November", "Nov", "December", "Dec"
    };
    int month_num [NAME_COUNT] = '{
        1, 1, 2, 2, 3, 3, 4, 4, 5, 6, 6, 7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12
    };

    // Directed strings; a tilde stands for a NUL character
    typedef struct {
        string   text;
        bit      typed;
        result_t want;
    } probe_t;

    probe_t probes [7] = '{
        '{",",       1'b1, '{16'd0, 16'd0, 16'd0, FMT_COMMA, ST_EMPTY}},
        '{"~\377",   1'b1, '{16'd0, 16'd0, 16'd0, FMT_NONE, ST_NO_FORMAT}},
        '{"May 1,9", 1'b0, '{16'd0, 16'd0, 16'd0, FMT_NONE, ST_OK}},
        '{"9/65535", 1'b1, '{16'd65535, 16'd9, 16'd65535, FMT_SLASH, ST_OK}},
        '{"/70000",  1'b1, '{16'd0, 16'd0, 16'd0, FMT_SLASH, ST_OVERFLOW}},
        '{"- 1 2",   1'b1, '{16'd0, 16'd0, 16'd0, FMT_SPACE, ST_NO_DIGITS}},
        '{" 5 7",    1'b1, '{16'd0, 16'd0, 16'd0, FMT_SPACE, ST_EMPTY}}
    };

    // Scan state of the parser's expected behavior
    logic                  scan_comma;
    logic                  scan_slash;
    logic [1:0]            scan_spaces;
    logic                  scan_first;
    logic [NAME_COUNT-1:0] scan_names;
    logic [POS_BITS-1:0]   scan_pos;
    acc_t                  scan_num [ACC_COUNT];

    date_text_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    // Clear the scan state between strings
    function automatic void clear_scan();
        scan_comma  = 1'b0;
        scan_slash  = 1'b0;
        scan_spaces = 2'd0;
        scan_first  = 1'b1;
        scan_names  = '1;
        scan_pos    = '0;
        foreach (scan_num[i]) begin
            scan_num[i] = '{'0, PH_IDLE};
        end
    endfunction

    // Advance one number accumulator by a character
    function automatic acc_t feed_num(input acc_t a, input logic [7:0] c);
        logic            dig;
        longint unsigned v;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        case (a.phase)
            PH_FRESH, PH_BLANK: begin
                if (blank_char(c)) begin
                    a.phase = PH_BLANK;
                end else if (dig) begin
                    a.num   = VALUE_BITS'(c - CH_ZERO);
                    a.phase = PH_DIGITS;
                end else begin
                    a.phase = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (dig) begin
                    v = longint'(a.num) * 10 + longint'(c - CH_ZERO);
                    if (v > (64'd1 << VALUE_BITS) - 1) begin
                        a.phase = PH_OVER;
                    end else begin
                        a.num = VALUE_BITS'(v);
                    end
                end else begin
                    a.phase = PH_DONE;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] num_status(input acc_t a);
        case (a.phase)
            PH_DIGITS, PH_DONE: return ST_OK;
            PH_OVER:            return ST_OVERFLOW;
            PH_IDLE, PH_FRESH:  return ST_EMPTY;
            default:            return ST_NO_DIGITS;
        endcase
    endfunction

    // Take one character; on the final one, give the parsed date and clear
    function automatic bit advance_scan(input logic [7:0] c, input bit last,
                                        output result_t r);
        bit         sp;
        bit         empty;
        bit         named;
        acc_t       ya;
        acc_t       da;
        logic [2:0] s;
        sp = (c == CH_SPACE);
        r  = '0;

        // Restart the accumulators that this character opens
        if (scan_first) begin
            scan_num[ACC_PREFIX] = '{'0, PH_FRESH};
        end
        if (sp) begin
            if (scan_spaces == 2'd0) begin
                scan_num[ACC_DAY_SPACE] = '{'0, PH_FRESH};
            end
            scan_num[ACC_YEAR_SPACE] = '{'0, PH_FRESH};
        end
        foreach (scan_num[i]) begin
            scan_num[i] = feed_num(scan_num[i], c);
        end

        // Narrow the month-name candidates up to the first space
        if ((scan_spaces == 2'd0) && !sp) begin
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (scan_pos >= month_txt[i].len() || month_txt[i][scan_pos] != c) begin
                    scan_names[i] = 1'b0;
                end
            end
            if (scan_pos != '1) begin
                scan_pos++;
            end
        end

        // Separators open the fields after them
        if ((c == CH_COMMA) && !scan_comma) begin
            scan_num[ACC_YEAR_COMMA] = '{'0, PH_FRESH};
            scan_comma = 1'b1;
        end
        if (c == CH_SLASH) begin
            if (!scan_slash) begin
                scan_num[ACC_DAY_SLASH] = '{'0, PH_FRESH};
            end
            scan_num[ACC_YEAR_SLASH] = '{'0, PH_FRESH};
            scan_slash = 1'b1;
        end
        if (sp && (scan_spaces < 2'd2)) begin
            scan_spaces++;
        end
        scan_first = 1'b0;

        if (!last) begin
            return 1'b0;
        end

        // Pick the form by priority and read its fields
        ya    = '{'0, PH_IDLE};
        da    = '{'0, PH_IDLE};
        empty = 1'b0;
        named = 1'b0;
        r.format_code = FMT_NONE;
        if (scan_comma) begin
            r.format_code = FMT_COMMA;
            ya    = scan_num[ACC_YEAR_COMMA];
            da    = scan_num[ACC_DAY_SPACE];
            empty = (scan_pos == '0) && (scan_spaces != 2'd0);
        end else if (scan_slash) begin
            r.format_code = FMT_SLASH;
            ya = scan_num[ACC_YEAR_SLASH];
            da = scan_num[ACC_DAY_SLASH];
        end else if (scan_spaces >= 2'd2) begin
            r.format_code = FMT_SPACE;
            ya    = scan_num[ACC_YEAR_SPACE];
            da    = scan_num[ACC_DAY_SPACE];
            empty = (scan_pos == '0) && (scan_spaces != 2'd0);
        end

        if (r.format_code == FMT_NONE) begin
            r.parse_status = ST_NO_FORMAT;
        end else begin
            if (ya.phase == PH_IDLE || ya.phase == PH_FRESH ||
                da.phase == PH_IDLE || da.phase == PH_FRESH) begin
                empty = 1'b1;
            end
            if (empty) begin
                r.parse_status = ST_EMPTY;
            end else begin
                r.parse_status = num_status(ya);
                r.year_value   = ya.num;
                if (r.format_code != FMT_SLASH) begin
                    for (int i = 0; i < NAME_COUNT; i++) begin
                        if (scan_names[i] && (month_txt[i].len() == scan_pos)) begin
                            r.month_value = VALUE_BITS'(month_num[i]);
                            named = 1'b1;
                        end
                    end
                end
                if (!named) begin
                    s = num_status(scan_num[ACC_PREFIX]);
                    r.month_value = scan_num[ACC_PREFIX].num;
                    if (r.parse_status == ST_OK) begin
                        r.parse_status = s;
                    end
                end
                s = num_status(da);
                r.day_value = da.num;
                if (r.parse_status == ST_OK) begin
                    r.parse_status = s;
                end
            end
        end
        if (r.parse_status != ST_OK) begin
            r.year_value  = '0;
            r.month_value = '0;
            r.day_value   = '0;
        end
        clear_scan();
        return 1'b1;
    endfunction

    // Append a number: optional blank or sign, then mostly one to four digits
    function automatic void push_number();
        int n;
        if ($urandom_range(7) == 0) begin
            line_q.push_back($urandom_range(1) ? CH_SPACE : 8'(8'h09 + $urandom_range(4)));
        end
        if ($urandom_range(15) == 0) begin
            line_q.push_back($urandom_range(1) ? "+" : "-");
        end
        case ($urandom_range(15))
            0:       n = 0;
            1:       n = 5;
            2:       n = 6;
            default: n = $urandom_range(1, 4);
        endcase
        repeat (n) begin
            line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
    endfunction

    // Append a month: a number now and then, else a name, sometimes garbled
    function automatic void push_month();
        string t;
        if ($urandom_range(3) == 0) begin
            push_number();
        end else begin
            t = month_txt[$urandom_range(NAME_COUNT - 1)];
            for (int k = 0; k < t.len(); k++) begin
                line_q.push_back(t[k]);
            end
            case ($urandom_range(9))
                0:       line_q.push_back(8'($urandom_range(255)));
                1:       void'(line_q.pop_back());
                default: ;
            endcase
        end
    endfunction

    // Build one random date string: mostly well-formed, some noise
    function automatic void build_line();
        int form;
        line_q.delete();
        form = $urandom_range(19);
        if (form < 3) begin
            repeat ($urandom_range(1, 6)) begin
                line_q.push_back(8'($urandom_range(255)));
            end
        end else if (form < 9) begin
            push_month();
            line_q.push_back(CH_SPACE);
            push_number();
            line_q.push_back(CH_COMMA);
            if ($urandom_range(1)) begin
                line_q.push_back(CH_SPACE);
            end
            push_number();
        end else if (form < 14) begin
            push_number();
            line_q.push_back(CH_SLASH);
            push_number();
            if ($urandom_range(4) != 0) begin
                line_q.push_back(CH_SLASH);
                push_number();
            end
        end else begin
            push_month();
            line_q.push_back(CH_SPACE);
            push_number();
            line_q.push_back(CH_SPACE);
            if ($urandom_range(5) == 0) begin
                line_q.push_back(CH_SPACE);
            end
            push_number();
        end
        // Corrupt one character now and then
        if ((line_q.size() > 0) && ($urandom_range(9) == 0)) begin
            line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
        end
    endfunction

    // Offer one character, wait for its transfer, then log what it should give
    task automatic drive_char(input logic [7:0] c, input bit last, input bit typed,
                              input result_t want);
        result_t got;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
        if (advance_scan(c, last, got)) begin
            dates_due.push_back(typed ? want : got);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Compare each result transfer with the oldest expected date
    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.year_value   = m_tdata[15:0];
            got.month_value  = m_tdata[31:16];
            got.day_value    = m_tdata[47:32];
            got.format_code  = m_tdata[49:48];
            got.parse_status = m_tdata[52:50];
            if (dates_due.size() == 0) begin
                flag_error($sformatf("result %0d with nothing expected", result_count));
            end else begin
                want = dates_due.pop_front();
                if (got !== want || m_tdata[55:53] !== 3'b000) begin
                    flag_error($sformatf(
                        "result %0d: got y=%0d m=%0d d=%0d f=%0d s=%0d pad=%b, want y=%0d m=%0d d=%0d f=%0d s=%0d",
                        result_count, got.year_value, got.month_value, got.day_value,
                        got.format_code, got.parse_status, m_tdata[55:53],
                        want.year_value, want.month_value, want.day_value,
                        want.format_code, want.parse_status));
                end
            end
            result_count++;
        end
    end

    initial begin : stimulus
        logic [7:0] ch;
        int         sent;
        clear_scan();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            send_gap_pct   = GAP_PCT[phase];
            sink_stall_pct = STALL_PCT[phase];

            if (phase == 0) begin
                // Walk the directed table
                foreach (probes[p]) begin
                    for (int k = 0; k < probes[p].text.len(); k++) begin
                        ch = probes[p].text[k];
                        if (ch == "~") begin
                            ch = 8'h00;
                        end
                        drive_char(ch, k == probes[p].text.len() - 1, probes[p].typed,
                                   probes[p].want);
                    end
                end
                // Hold off the results while single-character strings pile up
                hold_go = 1'b1;
                repeat (PRESSURE_ITEMS) begin
                    drive_char(8'($urandom_range(255)), 1'b1, 1'b0, '0);
                end
            end

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_line();
                foreach (line_q[k]) begin
                    drive_char(line_q[k], k == line_q.size() - 1, 1'b0, '0);
                end
                sent += line_q.size();
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding dates, then allow for the pipeline
        while (dates_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (error_count == 0 && dates_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("timeout with %0d dates outstanding", dates_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
